FILE: rtl/mcpw_pkg.sv
`default_nettype none

package mcpw_pkg;

    // Default sizing of the timer table
    localparam int DEF_NUM_CLIENTS = 16;
    localparam int DEF_TIME_WIDTH  = 48;

    // Fixed field widths of the request and result channels
    localparam int CLIENT_W   = 4;
    localparam int AMOUNT_W   = 32;
    localparam int INTERVAL_W = 48;

    // Most wakes that one tick may raise
    localparam int MAX_RESULTS = 16;

    // Default interval: 25000 years of seconds-per-year units
    localparam logic [63:0] YEARS_DEFAULT  = 64'(25 * 1000);
    localparam logic [63:0] UNITS_PER_YEAR = 64'(86400 * 365);
    localparam logic [63:0] DEFAULT_INTERVAL = YEARS_DEFAULT * UNITS_PER_YEAR;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_TICK         = 2'd0,
        KIND_SET_INTERVAL = 2'd1,
        KIND_SET_PRESENCE = 2'd2,
        KIND_START        = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/mcpw_slot_store.sv
`default_nettype none

module mcpw_slot_store
    import mcpw_pkg::*;
#(
    parameter int NUM_CLIENTS = DEF_NUM_CLIENTS,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
    localparam int AW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [AW-1:0]         i_rd_addr,
    output logic      [TIME_WIDTH-1:0] o_rd_interval,
    output logic      [TIME_WIDTH-1:0] o_rd_next_due,
    input  wire logic                  i_wr_en,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire logic [TIME_WIDTH-1:0] i_wr_interval,
    input  wire logic [TIME_WIDTH-1:0] i_wr_next_due
);

    localparam int TW = TIME_WIDTH;
    localparam logic [63:0]   TIME_MASK64 = ~64'd0 >> (64 - TW);
    localparam logic [TW-1:0] TIME_ONES   = {TW{1'b1}};
    localparam logic [TW-1:0] DEF_IV      =
        (DEFAULT_INTERVAL > TIME_MASK64) ? TIME_ONES : TW'(DEFAULT_INTERVAL);

    // One row per client: {interval, next_due}
    logic [2*TW-1:0]        r_mem [NUM_CLIENTS];
    logic [2*TW-1:0]        r_rd;
    logic [NUM_CLIENTS-1:0] r_valid;
    logic                   r_rd_valid;

    // Write and read the row array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_interval, i_wr_next_due};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // Track rows written since reset; sample the flag with the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // Substitute reset values for rows never written
    assign o_rd_interval = r_rd_valid ? r_rd[2*TW-1:TW] : DEF_IV;
    assign o_rd_next_due = r_rd_valid ? r_rd[TW-1:0]    : TIME_ONES;

endmodule

`default_nettype wire

FILE: rtl/multi_client_periodic_wakeup.sv
`default_nettype none

// Channel    Handshake                  Payload
// ---------  -------------------------  -----------------------------------------------
// request    i_in_valid / o_in_stall    i_kind, i_client, i_tick_amount,
//                                       i_interval_value, i_present_flag
// result     o_out_valid / i_out_stall  o_target_client, o_is_broadcast_start, o_last
//
// Set-interval and presence requests finish in idle without a scan. A tick with a nonzero
// amount or a start scans every slot, and the result side can stall the scan:
// the slot store has one read port and the scan reads one slot per cycle when not stalled.
// Synchronous active-low reset; no clearing pass, rows never written read as their
// reset values. New requests wait while a scan or its final result is pending.

module multi_client_periodic_wakeup
    import mcpw_pkg::*;
#(
    parameter int NUM_CLIENTS = DEF_NUM_CLIENTS,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_kind,
    input  wire logic [CLIENT_W-1:0]   i_client,
    input  wire logic [AMOUNT_W-1:0]   i_tick_amount,
    input  wire logic [INTERVAL_W-1:0] i_interval_value,
    input  wire logic                  i_present_flag,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [CLIENT_W-1:0]   o_target_client,
    output logic                       o_is_broadcast_start,
    output logic                       o_last
);

    localparam int TW   = TIME_WIDTH;
    localparam int AW   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int RW   = $clog2(NUM_CLIENTS + 1);
    localparam int CNTW = $clog2(MAX_RESULTS + 1);
    localparam logic [63:0]   TIME_MASK64 = ~64'd0 >> (64 - TW);
    localparam logic [TW-1:0] TIME_ONES   = {TW{1'b1}};
    localparam logic [TW-1:0] TIME_ONE    = TW'(1);

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? TIME_ONES : s[TW-1:0];
    endfunction

    t_state               r_state;
    t_state               n_state;
    logic [TW-1:0]        r_time;
    logic [NUM_CLIENTS-1:0] r_present;
    logic                 r_start;
    logic [RW-1:0]        r_ra;
    logic                 r_pv;
    logic [AW-1:0]        r_pi;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_hv;
    logic [CLIENT_W-1:0]  r_ht;
    logic                 r_hb;
    logic                 r_ov;
    logic [CLIENT_W-1:0]  r_ot;
    logic                 r_ob;
    logic                 r_ol;

    t_kind                kind;
    logic                 in_acc;
    logic                 cli_ok;
    logic [AW-1:0]        cli_idx;
    logic [TW-1:0]        iv_in;
    logic [TW-1:0]        amt;
    logic                 scan_req;
    logic                 out_free;
    logic                 st_idle;
    logic                 st_scan;
    logic                 st_flush;

    logic [TW-1:0]        rd_iv;
    logic [TW-1:0]        rd_nd;
    logic [TW-1:0]        add_a;
    logic [TW-1:0]        add_b;
    logic [TW-1:0]        nd_next;
    logic                 due;
    logic                 fire;
    logic                 go;
    logic                 proc_done;
    logic                 ra_done;
    logic                 issue;
    logic                 push_scan;
    logic                 push_flush;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [TW-1:0]        wr_iv;
    logic [TW-1:0]        wr_nd;

    // Decode the incoming request
    assign kind     = t_kind'(i_kind);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign cli_ok   = int'(i_client) < NUM_CLIENTS;
    assign cli_idx  = AW'(i_client);
    assign iv_in    = (64'(i_interval_value) > TIME_MASK64) ? TIME_ONES
                                                            : TW'(i_interval_value);
    assign amt      = TW'(i_tick_amount);
    assign scan_req = (kind == KIND_START) || (kind == KIND_TICK && i_tick_amount != '0);
    assign out_free = !r_ov || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && scan_req) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (ra_done && (!r_pv || go)) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!r_hv || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        st_idle  = 1'b0;
        st_scan  = 1'b0;
        st_flush = 1'b0;
        unique case (r_state)
            ST_IDLE:  st_idle  = 1'b1;
            ST_SCAN:  st_scan  = 1'b1;
            ST_FLUSH: st_flush = 1'b1;
            default:  st_idle  = 1'b0;
        endcase
    end

    assign o_in_stall = !st_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Slot being processed: check due time and compute the next one
    assign due     = r_present[r_pi] && (rd_nd != TIME_ONES) && (r_time >= rd_nd)
                     && (r_cnt < CNTW'(MAX_RESULTS));
    assign add_a   = (rd_iv == TIME_ONE) ? r_time   : rd_nd;
    assign add_b   = (rd_iv == TIME_ONE) ? TIME_ONE : rd_iv;
    assign nd_next = sat_add(add_a, add_b);
    assign fire    = r_pv && !r_start && due;

    // A second wake must first move the held one out
    assign go         = !(fire && r_hv) || out_free;
    assign proc_done  = r_pv && go;
    assign ra_done    = (r_ra == RW'(NUM_CLIENTS));
    assign issue      = st_scan && !ra_done && (!r_pv || go);
    assign push_scan  = proc_done && fire && r_hv;
    assign push_flush = st_flush && r_hv && out_free;

    // Store write: set-interval from idle, write-back from the scan.
    // The scan reads slot i+1 while writing slot i, so no entry overlaps.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pi;
        wr_iv   = rd_iv;
        wr_nd   = nd_next;
        if (in_acc && kind == KIND_SET_INTERVAL && cli_ok) begin
            wr_en   = 1'b1;
            wr_addr = cli_idx;
            wr_iv   = iv_in;
            wr_nd   = (iv_in != '0) ? sat_add(r_time, iv_in) : TIME_ONES;
        end else if (proc_done && r_start) begin
            wr_en   = 1'b1;
            wr_nd   = (rd_iv != '0) ? rd_iv : TIME_ONES;
        end else if (proc_done && fire) begin
            wr_en   = 1'b1;
        end
    end

    mcpw_slot_store #(
        .NUM_CLIENTS(NUM_CLIENTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (issue),
        .i_rd_addr     (r_ra[AW-1:0]),
        .o_rd_interval (rd_iv),
        .o_rd_next_due (rd_nd),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_interval (wr_iv),
        .i_wr_next_due (wr_nd)
    );

    // Advance time on a tick, clear it on a start, track presence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_present <= '0;
        end else if (in_acc) begin
            case (kind)
                KIND_TICK:         r_time <= sat_add(r_time, amt);
                KIND_START:        r_time <= '0;
                KIND_SET_PRESENCE: begin
                    if (cli_ok) r_present[cli_idx] <= i_present_flag;
                end
                default:           r_time <= r_time;
            endcase
        end
    end

    // Scan pointers and wake count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra    <= '0;
            r_pv    <= 1'b0;
            r_cnt   <= '0;
            r_start <= 1'b0;
        end else begin
            if (in_acc && scan_req) begin
                r_ra    <= '0;
                r_cnt   <= '0;
                r_start <= (kind == KIND_START);
            end else begin
                if (issue) r_ra <= r_ra + RW'(1);
                if (proc_done && fire) r_cnt <= r_cnt + CNTW'(1);
            end
            if (issue)          r_pv <= 1'b1;
            else if (proc_done) r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) r_pi <= r_ra[AW-1:0];
    end

    // Hold the newest result until the next one shows it was not the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (in_acc && kind == KIND_START) begin
            r_hv <= 1'b1;
        end else if (proc_done && fire) begin
            r_hv <= 1'b1;
        end else if (push_flush) begin
            r_hv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && kind == KIND_START) begin
            r_ht <= '0;
            r_hb <= 1'b1;
        end else if (proc_done && fire) begin
            r_ht <= CLIENT_W'(r_pi);
            r_hb <= 1'b0;
        end
    end

    // Output register: load from the hold stage, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (push_scan || push_flush) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_scan || push_flush) begin
            r_ot <= r_ht;
            r_ob <= r_hb;
            r_ol <= push_flush;
        end
    end

    assign o_out_valid          = r_ov;
    assign o_target_client      = r_ot;
    assign o_is_broadcast_start = r_ob;
    assign o_last               = r_ol;

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_idle |-> !r_hv)
        else $error("held result left behind in idle");

    a_wake_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(MAX_RESULTS))
        else $error("wake count beyond limit");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (RW'(r_pi) + RW'(1)) == r_ra)
        else $error("scan read and process slots out of step");

    a_bcast_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ob) |-> (r_ol && r_ot == '0))
        else $error("start broadcast not a lone final result");
`endif

endmodule

`default_nettype wire
